/* src/lem_pkg.sv */
// Shared types, mode codes and level helpers for the LED effect mode engine.
// No dependencies; used by every module of the block except lem_checker.
`timescale 1ns / 1ps

package lem_pkg;

   localparam int LEVEL_FP_BITS = 8;
   localparam int LEVEL_W       = 2 * LEVEL_FP_BITS;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(255 << LEVEL_FP_BITS);
   localparam logic [LEVEL_W-1:0] HALF_LEVEL = LEVEL_W'(255 << (LEVEL_FP_BITS - 1));

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_SET   = 2'd2;
   localparam logic [1:0] KIND_NUDGE = 2'd3;

   // mode codes
   localparam logic [4:0] MODE_OFF          = 5'd0;
   localparam logic [4:0] MODE_ON           = 5'd1;
   localparam logic [4:0] MODE_LOW          = 5'd2;
   localparam logic [4:0] MODE_HIGH         = 5'd3;
   localparam logic [4:0] MODE_TOGGLE       = 5'd4;
   localparam logic [4:0] MODE_TOGGLE_MAX   = 5'd5;
   localparam logic [4:0] MODE_TOGGLE_LEVEL = 5'd6;
   localparam logic [4:0] MODE_BLINK        = 5'd7;
   localparam logic [4:0] MODE_BLINK_MAX    = 5'd8;
   localparam logic [4:0] MODE_BLINK_LEVEL  = 5'd9;
   localparam logic [4:0] MODE_STEP_DOWN    = 5'd10;
   localparam logic [4:0] MODE_STEP_UP      = 5'd11;
   localparam logic [4:0] MODE_FADE_DOWN    = 5'd12;
   localparam logic [4:0] MODE_FADE_UP      = 5'd13;
   localparam logic [4:0] MODE_FADE_REVERSE = 5'd14;
   localparam logic [4:0] MODE_OSCILLATE    = 5'd15;
   localparam logic [4:0] MODE_HOLD         = 5'd16;
   localparam logic [4:0] MODE_LAST         = MODE_HOLD;

   // register indexes
   localparam logic [2:0] CSR_LEVEL_MIN     = 3'd0;
   localparam logic [2:0] CSR_LEVEL_MAX     = 3'd1;
   localparam logic [2:0] CSR_LEVEL_STEP    = 3'd2;
   localparam logic [2:0] CSR_USE_PWM       = 3'd3;
   localparam logic [2:0] CSR_INVERT_OUTPUT = 3'd4;
   localparam logic [2:0] CSR_BLINK_PERIOD  = 3'd5;
   localparam logic [2:0] CSR_REFRESH       = 3'd6;

   typedef struct packed {
      logic [7:0]  level_min;
      logic [7:0]  level_max;
      logic [15:0] level_step;
      logic        use_pwm;
      logic        invert_output;
      logic [15:0] blink_period;
      logic [15:0] refresh_interval;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  mode;
      logic [15:0] phase_count;
      logic [7:0]  step_amount;
      logic [7:0]  new_level;
      logic        nudge_up;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_fixed;
      logic               direction_up;
      logic [4:0]         requested_mode;
      logic [4:0]         current_mode;
      logic [15:0]        phases_left;
      logic [15:0]        step_interval;
      logic [15:0]        ticks_since_drive;
   } state_type;

   typedef struct packed {
      logic       pin_on;
      logic [7:0] pin_duty;
      logic [7:0] level_now;
      logic [4:0] active_mode;
      logic       accepted;
      logic       updated;
      logic       rising;
      logic       falling;
   } result_type;

   function automatic logic [LEVEL_W-1:0] lvl_up(input logic [LEVEL_W-1:0] level,
                                                 input logic [LEVEL_W-1:0] delta,
                                                 input logic [LEVEL_W-1:0] hi);
      logic [LEVEL_W:0] v;
      v = {1'b0, level} + {1'b0, delta};
      return (v > {1'b0, hi}) ? hi : v[LEVEL_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] lvl_down(input logic [LEVEL_W-1:0] level,
                                                   input logic [LEVEL_W-1:0] delta,
                                                   input logic [LEVEL_W-1:0] lo);
      logic [LEVEL_W-1:0] d;
      d = level - delta;
      return ((level < delta) || (d < lo)) ? lo : d;
   endfunction

   // digital remap without PWM, then toggle / blink resolved from the running mode
   function automatic logic [4:0] adjust_mode(input logic [4:0] m,
                                              input logic [4:0] cur,
                                              input logic       pwm);
      logic [4:0] r;
      r = m;
      if (!pwm) begin
         if (m inside {MODE_HIGH, MODE_STEP_UP, MODE_FADE_UP}) r = MODE_ON;
         else if (m inside {MODE_LOW, MODE_STEP_DOWN, MODE_FADE_DOWN}) r = MODE_OFF;
         else if (m == MODE_FADE_REVERSE) r = MODE_TOGGLE_MAX;
         else if (m inside {MODE_BLINK_LEVEL, MODE_OSCILLATE}) r = MODE_BLINK_MAX;
         else if (m == MODE_HOLD) r = cur;
      end
      if (m == MODE_TOGGLE) begin
         if (cur inside {MODE_OFF, MODE_ON, MODE_BLINK_MAX}) r = MODE_TOGGLE_MAX;
         else r = MODE_TOGGLE_LEVEL;
      end
      if (m == MODE_BLINK) begin
         if (cur inside {MODE_BLINK_MAX, MODE_BLINK_LEVEL}) r = cur;
         else if (cur inside {MODE_OFF, MODE_ON}) r = MODE_BLINK_MAX;
         else r = MODE_BLINK_LEVEL;
      end
      return r;
   endfunction

endpackage

/* src/led_effect_mode_engine.sv */
// LED effect mode engine: request register, lem_step logic, state and result registers.
// Path from request accept to rsp_tvalid: request register, then result register.
// Throughput: one request per cycle; a result waiting on rsp_tready stalls the request register and stops intake.
// Reset (synchronous, active high): LED off, modes off, counters cleared, registers defaults.
// Depends on lem_pkg and lem_step.
`timescale 1ns / 1ps

module led_effect_mode_engine
   import lem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // mode[4:0], phase_count[20:5], step_amount[28:21],
                                    // new_level[36:29], nudge_up[37], zero pad
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pin_on[0], pin_duty[8:1], level_now[16:9],
                                    // active_mode[21:17], accepted[22], updated[23],
                                    // rising[24], falling[25], zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff, item_in;
   logic       item_valid_ff;
   state_type  state_ff, state_in;
   result_type result_in, result_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign item_in.kind        = req_tuser;
   assign item_in.mode        = req_tdata[4:0];
   assign item_in.phase_count = req_tdata[20:5];
   assign item_in.step_amount = req_tdata[28:21];
   assign item_in.new_level   = req_tdata[36:29];
   assign item_in.nudge_up    = req_tdata[37];

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   lem_step u_step (
      .state_q (state_ff),
      .cfg     (cfg_ff),
      .item    (item_ff),
      .state_d (state_in),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_min        <= 8'd0;
         cfg_ff.level_max        <= 8'd255;
         cfg_ff.level_step       <= 16'd256;
         cfg_ff.use_pwm          <= 1'b1;
         cfg_ff.invert_output    <= 1'b0;
         cfg_ff.blink_period     <= 16'd1000;
         cfg_ff.refresh_interval <= 16'd10;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LEVEL_MIN:     cfg_ff.level_min        <= csr_wdata[7:0];
            CSR_LEVEL_MAX:     cfg_ff.level_max        <= csr_wdata[7:0];
            CSR_LEVEL_STEP:    cfg_ff.level_step       <= csr_wdata;
            CSR_USE_PWM:       cfg_ff.use_pwm          <= csr_wdata[0];
            CSR_INVERT_OUTPUT: cfg_ff.invert_output    <= csr_wdata[0];
            CSR_BLINK_PERIOD:  cfg_ff.blink_period     <= csr_wdata;
            CSR_REFRESH:       cfg_ff.refresh_interval <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.level_fixed       <= '0;
         state_ff.direction_up      <= 1'b0;
         state_ff.requested_mode    <= MODE_OFF;
         state_ff.current_mode      <= MODE_OFF;
         state_ff.phases_left       <= '0;
         state_ff.step_interval     <= '0;
         state_ff.ticks_since_drive <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, result_ff.falling, result_ff.rising, result_ff.updated,
                        result_ff.accepted, result_ff.active_mode, result_ff.level_now,
                        result_ff.pin_duty, result_ff.pin_on};

endmodule

/* src/lem_step.sv */
// Next-state and result logic for one request of the LED effect mode engine.
// Purely combinational; depends on lem_pkg.
`timescale 1ns / 1ps

module lem_step
   import lem_pkg::*;
(
   input  state_type  state_q,
   input  cfg_type    cfg,
   input  item_type   item,
   output state_type  state_d,
   output result_type result
);

   logic [7:0]         lo_w, hi_w;
   logic [LEVEL_W-1:0] lo, hi, mid;
   logic [LEVEL_W-1:0] step_def, cmd_step, nudge_delta;
   logic [15:0]        refresh_eff, bp_eff, blink_half, ticks_inc;
   logic [LEVEL_W-1:0] up_def, dn_def, up_cmd, dn_cmd, up_nudge, dn_nudge;
   logic [LEVEL_W-1:0] tgt, eff16;
   logic [7:0]         eff;

   always_comb begin
      if (cfg.level_min < cfg.level_max) begin
         lo_w = cfg.level_min;
         hi_w = cfg.level_max;
      end else if (cfg.level_min > cfg.level_max) begin
         lo_w = cfg.level_max;
         hi_w = cfg.level_min;
      end else if (cfg.level_min == 8'd0) begin
         lo_w = 8'd0;
         hi_w = 8'd1;
      end else begin
         lo_w = cfg.level_max - 8'd1;
         hi_w = cfg.level_max;
      end
   end

   assign lo          = {lo_w, {LEVEL_FP_BITS{1'b0}}};
   assign hi          = {hi_w, {LEVEL_FP_BITS{1'b0}}};
   assign mid         = lo + ((hi - lo) >> 1);
   assign step_def    = (cfg.level_step == '0) ? LEVEL_W'(1) : cfg.level_step;
   assign refresh_eff = (cfg.refresh_interval == '0) ? 16'd1 : cfg.refresh_interval;
   assign bp_eff      = (cfg.blink_period < 16'd2) ? 16'd2 : cfg.blink_period;
   assign blink_half  = bp_eff >> 1;
   assign ticks_inc   = (state_q.ticks_since_drive == 16'hFFFF) ? 16'hFFFF
                                                                : state_q.ticks_since_drive + 16'd1;
   assign tgt         = {item.new_level, {LEVEL_FP_BITS{1'b0}}};

   // only a mode command or a nudge carries its own step; ticks and level sets use the default
   assign cmd_step    = (item.kind == KIND_CMD && item.step_amount != 8'd0)
                        ? {8'd0, item.step_amount} : step_def;
   assign nudge_delta = (item.step_amount == 8'd0) ? step_def
                        : {item.step_amount, {LEVEL_FP_BITS{1'b0}}};

   assign up_def   = lvl_up(state_q.level_fixed, step_def, hi);
   assign dn_def   = lvl_down(state_q.level_fixed, step_def, lo);
   assign up_cmd   = lvl_up(state_q.level_fixed, cmd_step, hi);
   assign dn_cmd   = lvl_down(state_q.level_fixed, cmd_step, lo);
   assign up_nudge = lvl_up(state_q.level_fixed, nudge_delta, hi);
   assign dn_nudge = lvl_down(state_q.level_fixed, nudge_delta, lo);

   always_comb begin
      state_type          s;
      logic               acc, upd, do_cmp, d, near, at_edge;
      logic [4:0]         spec, set_mode;
      logic [15:0]        phases, pl, pl2;
      logic [LEVEL_W-1:0] nl, bhi, blo;

      s        = state_q;
      acc      = 1'b0;
      upd      = 1'b0;
      do_cmp   = 1'b0;
      spec     = MODE_OFF;
      set_mode = MODE_OFF;
      phases   = '0;
      d        = 1'b0;
      near     = 1'b0;
      at_edge  = 1'b0;
      pl       = '0;
      pl2      = '0;
      nl       = '0;
      bhi      = '0;
      blo      = '0;

      case (item.kind)
         KIND_TICK: begin
            s.ticks_since_drive = ticks_inc;
            if (state_q.step_interval != '0 && ticks_inc >= state_q.step_interval) begin
               do_cmp = 1'b1;
               spec   = state_q.current_mode;
               upd    = 1'b1;
            end
         end
         KIND_CMD: begin
            if (item.mode <= MODE_LAST) begin
               spec   = adjust_mode(item.mode, state_q.current_mode, cfg.use_pwm);
               do_cmp = (spec != state_q.requested_mode);
               phases = item.phase_count;
            end
         end
         KIND_SET: begin
            acc = 1'b1;
            if (item.new_level == 8'd0 || item.new_level == 8'd255 || tgt == lo || tgt == hi) begin
               if (item.new_level == 8'd0) set_mode = MODE_OFF;
               else if (item.new_level == 8'd255) set_mode = MODE_ON;
               else if (tgt == lo) set_mode = MODE_LOW;
               else set_mode = MODE_HIGH;
               spec   = adjust_mode(set_mode, state_q.current_mode, cfg.use_pwm);
               do_cmp = (spec != state_q.requested_mode);
            end else if (cfg.use_pwm) begin
               acc = (tgt >= lo) && (tgt <= hi);
               if (tgt < lo) s.level_fixed = lo;
               else if (tgt > hi) s.level_fixed = hi;
               else s.level_fixed = tgt;
               s.requested_mode    = MODE_HOLD;
               s.current_mode      = MODE_HOLD;
               s.ticks_since_drive = '0;
            end else begin
               acc = 1'b0;
            end
         end
         default: begin
            s.level_fixed = item.nudge_up ? up_nudge : dn_nudge;
         end
      endcase

      if (do_cmp) begin
         s.requested_mode    = spec;
         s.ticks_since_drive = '0;
         case (spec)
            MODE_OFF, MODE_LOW: begin
               s.direction_up  = 1'b0;
               s.level_fixed   = (spec == MODE_OFF) ? '0 : lo;
               s.current_mode  = spec;
               s.step_interval = '0;
            end
            MODE_ON, MODE_HIGH: begin
               s.direction_up  = 1'b1;
               s.level_fixed   = (spec == MODE_ON) ? FULL_LEVEL : hi;
               s.current_mode  = spec;
               s.step_interval = '0;
            end
            MODE_TOGGLE_MAX: begin
               d               = !(state_q.level_fixed > HALF_LEVEL);
               s.direction_up  = d;
               s.level_fixed   = d ? FULL_LEVEL : '0;
               s.current_mode  = d ? MODE_ON : MODE_OFF;
               s.step_interval = '0;
            end
            MODE_TOGGLE_LEVEL: begin
               d               = !(state_q.level_fixed > mid);
               s.direction_up  = d;
               s.level_fixed   = d ? hi : lo;
               s.current_mode  = d ? MODE_HIGH : MODE_LOW;
               s.step_interval = '0;
            end
            MODE_BLINK_MAX, MODE_BLINK_LEVEL: begin
               if (spec == MODE_BLINK_MAX) begin
                  near = state_q.level_fixed > HALF_LEVEL;
                  bhi  = FULL_LEVEL;
                  blo  = '0;
               end else begin
                  near = state_q.level_fixed > mid;
                  bhi  = hi;
                  blo  = lo;
               end
               d              = !near;
               s.direction_up = d;
               s.level_fixed  = d ? bhi : blo;
               pl             = (phases != '0) ? phases : state_q.phases_left;
               pl2            = pl - 16'd1;
               if (pl != '0) begin
                  s.phases_left = pl2;
                  if (pl2 != '0) begin
                     s.current_mode  = spec;
                     s.step_interval = blink_half;
                  end else begin
                     if (spec == MODE_BLINK_MAX) s.current_mode = d ? MODE_ON : MODE_OFF;
                     else s.current_mode = d ? MODE_HIGH : MODE_LOW;
                     s.step_interval = '0;
                  end
               end else begin
                  s.phases_left   = '0;
                  s.current_mode  = spec;
                  s.step_interval = blink_half;
               end
            end
            MODE_STEP_DOWN: begin
               s.direction_up  = 1'b0;
               s.level_fixed   = dn_cmd;
               s.current_mode  = (dn_cmd == lo) ? MODE_LOW : MODE_HOLD;
               s.step_interval = '0;
            end
            MODE_STEP_UP: begin
               s.direction_up  = 1'b1;
               s.level_fixed   = up_cmd;
               s.current_mode  = (up_cmd == hi) ? MODE_HIGH : MODE_HOLD;
               s.step_interval = '0;
            end
            MODE_FADE_DOWN, MODE_FADE_UP, MODE_FADE_REVERSE: begin
               if (spec == MODE_FADE_DOWN) d = 1'b0;
               else if (spec == MODE_FADE_UP) d = 1'b1;
               else d = !state_q.direction_up;
               s.direction_up = d;
               if (d) begin
                  s.level_fixed   = up_def;
                  s.current_mode  = (up_def == hi) ? MODE_HIGH : MODE_FADE_UP;
                  s.step_interval = (up_def == hi) ? 16'd0 : refresh_eff;
               end else begin
                  s.level_fixed   = dn_def;
                  s.current_mode  = (dn_def == lo) ? MODE_LOW : MODE_FADE_DOWN;
                  s.step_interval = (dn_def == lo) ? 16'd0 : refresh_eff;
               end
            end
            MODE_OSCILLATE: begin
               // reverse first when sitting on a bound, then step
               d = (state_q.level_fixed == lo || state_q.level_fixed == hi)
                   ? !state_q.direction_up : state_q.direction_up;
               nl             = d ? up_def : dn_def;
               s.direction_up = d;
               s.level_fixed  = nl;
               pl             = (phases != '0) ? phases : state_q.phases_left;
               pl2            = pl - 16'd1;
               at_edge        = (nl == lo) || (nl == hi);
               if (pl != '0 && at_edge) begin
                  s.phases_left = pl2;
                  if (pl2 != '0) begin
                     s.current_mode  = MODE_OSCILLATE;
                     s.step_interval = refresh_eff;
                  end else begin
                     s.current_mode  = d ? MODE_HIGH : MODE_LOW;
                     s.step_interval = '0;
                  end
               end else begin
                  s.phases_left   = pl;
                  s.current_mode  = MODE_OSCILLATE;
                  s.step_interval = refresh_eff;
               end
            end
            MODE_HOLD: begin
               s.current_mode  = MODE_HOLD;
               s.step_interval = '0;
            end
            default: begin
            end
         endcase
      end

      state_d         = s;
      result.accepted = acc;
      result.updated  = upd;
   end

   assign eff16              = cfg.invert_output ? (FULL_LEVEL - state_d.level_fixed)
                                                 : state_d.level_fixed;
   assign eff                = eff16[LEVEL_W-1:LEVEL_FP_BITS];
   assign result.pin_on      = (eff != 8'd0);
   assign result.pin_duty    = (eff == 8'd0) ? 8'd0 : (cfg.use_pwm ? eff : 8'd255);
   assign result.level_now   = state_d.level_fixed[LEVEL_W-1:LEVEL_FP_BITS];
   assign result.active_mode = state_d.current_mode;
   assign result.rising      = (state_d.step_interval != '0) && state_d.direction_up;
   assign result.falling     = (state_d.step_interval != '0) && !state_d.direction_up;

endmodule

/* src/lem_checker.sv */
// Port-level checks for led_effect_mode_engine, attached by bind.
// Sees the top-level ports only; no package dependency.
`timescale 1ns / 1ps

module lem_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing comes out the cycle after reset
   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // pin_on follows the duty field
   a_pin_on: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[8:1] != 8'd0)))
      else $error("pin_on disagrees with pin_duty");

   // rising and falling exclusive; accepted and updated come from different kinds
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[24] && rsp_tdata[25]) && !(rsp_tdata[22] && rsp_tdata[23]))
      else $error("exclusive status flags both set");

endmodule

bind led_effect_mode_engine lem_checker u_lem_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/led_pin_checker.sv */
// Checker for the LED effect mode engine: watches the request, result and register ports,
// predicts each pin report from its own copy of the LED state and compares field by field.
// Depends on lem_pkg.
`timescale 1ns / 1ps

module led_pin_checker
   import lem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          waiting,
   output int          reports_seen,
   output int          timed_updates
);

   localparam int REPORT_LIMIT = 40;

   cfg_type    cfg;
   state_type  led;
   result_type expected_reports[$];
   int         mismatch_total = 0;
   int         report_total   = 0;
   int         update_total   = 0;

   initial begin
      mismatches    = 0;
      waiting       = 0;
      reports_seen  = 0;
      timed_updates = 0;
   end

   // bounds in 8.8, with swapped or equal register values sorted out
   function automatic int floor_level();
      int m, x, r;
      m = cfg.level_min;
      x = cfg.level_max;
      if (m < x) r = m;
      else if (m > x) r = x;
      else r = (m == 0) ? 0 : x - 1;
      return r << LEVEL_FP_BITS;
   endfunction

   function automatic int ceil_level();
      int m, x, r;
      m = cfg.level_min;
      x = cfg.level_max;
      if (m < x) r = x;
      else if (m > x) r = m;
      else r = (m == 0) ? 1 : x;
      return r << LEVEL_FP_BITS;
   endfunction

   function automatic int default_step();
      return (cfg.level_step == 0) ? 1 : int'(cfg.level_step);
   endfunction

   function automatic int refresh_ticks();
      return (cfg.refresh_interval == 0) ? 1 : int'(cfg.refresh_interval);
   endfunction

   function automatic int half_blink();
      return ((cfg.blink_period < 2) ? 2 : int'(cfg.blink_period)) / 2;
   endfunction

   task automatic raise_level(input int delta);
      int v, hi;
      v  = int'(led.level_fixed) + delta;
      hi = ceil_level();
      led.level_fixed = 16'((v > hi) ? hi : v);
   endtask

   task automatic lower_level(input int delta);
      int v, lo;
      v  = int'(led.level_fixed) - delta;
      lo = floor_level();
      led.level_fixed = 16'((v < lo) ? lo : v);
   endtask

   task automatic blink_step(input logic past_mid, input int hi, input int lo,
                             input logic [4:0] run, input logic [4:0] hi_mode,
                             input logic [4:0] lo_mode, input logic [15:0] phases);
      led.direction_up = !past_mid;
      led.level_fixed  = 16'(led.direction_up ? hi : lo);
      if (phases > 0) led.phases_left = phases;
      if (led.phases_left > 0) begin
         led.phases_left = led.phases_left - 16'd1;
         if (led.phases_left > 0) begin
            led.current_mode  = run;
            led.step_interval = 16'(half_blink());
         end else begin
            led.current_mode  = led.direction_up ? hi_mode : lo_mode;
            led.step_interval = '0;
         end
      end else begin
         led.current_mode  = run;
         led.step_interval = 16'(half_blink());
      end
   endtask

   task automatic run_mode(input logic [4:0] m, input logic [15:0] phases, input int step);
      int   lo, hi, mid;
      logic at_limit;
      lo  = floor_level();
      hi  = ceil_level();
      mid = lo + (hi - lo) / 2;
      if (step == 0) step = default_step();
      led.requested_mode = m;
      case (m)
         MODE_OFF: begin
            led.direction_up = 1'b0; led.level_fixed = '0;
            led.current_mode = MODE_OFF; led.step_interval = '0;
         end
         MODE_LOW: begin
            led.direction_up = 1'b0; led.level_fixed = 16'(lo);
            led.current_mode = MODE_LOW; led.step_interval = '0;
         end
         MODE_ON: begin
            led.direction_up = 1'b1; led.level_fixed = FULL_LEVEL;
            led.current_mode = MODE_ON; led.step_interval = '0;
         end
         MODE_HIGH: begin
            led.direction_up = 1'b1; led.level_fixed = 16'(hi);
            led.current_mode = MODE_HIGH; led.step_interval = '0;
         end
         MODE_TOGGLE_MAX: begin
            led.direction_up  = !(led.level_fixed > HALF_LEVEL);
            led.level_fixed   = led.direction_up ? FULL_LEVEL : '0;
            led.current_mode  = led.direction_up ? MODE_ON : MODE_OFF;
            led.step_interval = '0;
         end
         MODE_TOGGLE_LEVEL: begin
            led.direction_up  = !(led.level_fixed > mid);
            led.level_fixed   = 16'(led.direction_up ? hi : lo);
            led.current_mode  = led.direction_up ? MODE_HIGH : MODE_LOW;
            led.step_interval = '0;
         end
         MODE_BLINK_MAX:
            blink_step(led.level_fixed > HALF_LEVEL, FULL_LEVEL, 0, MODE_BLINK_MAX,
                       MODE_ON, MODE_OFF, phases);
         MODE_BLINK_LEVEL:
            blink_step(led.level_fixed > mid, hi, lo, MODE_BLINK_LEVEL,
                       MODE_HIGH, MODE_LOW, phases);
         MODE_STEP_DOWN: begin
            led.direction_up = 1'b0;
            lower_level(step);
            led.current_mode  = (led.level_fixed == lo) ? MODE_LOW : MODE_HOLD;
            led.step_interval = '0;
         end
         MODE_STEP_UP: begin
            led.direction_up = 1'b1;
            raise_level(step);
            led.current_mode  = (led.level_fixed == hi) ? MODE_HIGH : MODE_HOLD;
            led.step_interval = '0;
         end
         MODE_FADE_DOWN, MODE_FADE_UP, MODE_FADE_REVERSE: begin
            if (m == MODE_FADE_DOWN) led.direction_up = 1'b0;
            else if (m == MODE_FADE_UP) led.direction_up = 1'b1;
            else led.direction_up = !led.direction_up;
            if (led.direction_up) begin
               raise_level(default_step());
               if (led.level_fixed == hi) begin
                  led.current_mode = MODE_HIGH; led.step_interval = '0;
               end else begin
                  led.current_mode = MODE_FADE_UP; led.step_interval = 16'(refresh_ticks());
               end
            end else begin
               lower_level(default_step());
               if (led.level_fixed == lo) begin
                  led.current_mode = MODE_LOW; led.step_interval = '0;
               end else begin
                  led.current_mode = MODE_FADE_DOWN; led.step_interval = 16'(refresh_ticks());
               end
            end
         end
         MODE_OSCILLATE: begin
            if (led.level_fixed == lo || led.level_fixed == hi) led.direction_up = !led.direction_up;
            if (led.direction_up) raise_level(default_step());
            else lower_level(default_step());
            if (phases > 0) led.phases_left = phases;
            at_limit = (led.level_fixed == lo || led.level_fixed == hi);
            if (led.phases_left > 0 && at_limit) begin
               led.phases_left = led.phases_left - 16'd1;
               if (led.phases_left > 0) begin
                  led.current_mode = MODE_OSCILLATE; led.step_interval = 16'(refresh_ticks());
               end else begin
                  led.current_mode  = led.direction_up ? MODE_HIGH : MODE_LOW;
                  led.step_interval = '0;
               end
            end else begin
               led.current_mode = MODE_OSCILLATE; led.step_interval = 16'(refresh_ticks());
            end
         end
         MODE_HOLD: begin
            led.current_mode = MODE_HOLD; led.step_interval = '0;
         end
         default: ;
      endcase
   endtask

   // digital-only remap, then toggle and blink follow whatever is running now
   function automatic logic [4:0] resolve_mode(input logic [4:0] m);
      logic [4:0] r;
      r = m;
      if (!cfg.use_pwm) begin
         case (m)
            MODE_HIGH, MODE_STEP_UP, MODE_FADE_UP:    r = MODE_ON;
            MODE_LOW, MODE_STEP_DOWN, MODE_FADE_DOWN: r = MODE_OFF;
            MODE_FADE_REVERSE:                        r = MODE_TOGGLE_MAX;
            MODE_BLINK_LEVEL, MODE_OSCILLATE:         r = MODE_BLINK_MAX;
            MODE_HOLD:                                r = led.current_mode;
            default: ;
         endcase
      end
      if (m == MODE_TOGGLE) begin
         if (led.current_mode == MODE_OFF || led.current_mode == MODE_ON ||
             led.current_mode == MODE_BLINK_MAX)
            r = MODE_TOGGLE_MAX;
         else
            r = MODE_TOGGLE_LEVEL;
      end
      if (m == MODE_BLINK) begin
         if (led.current_mode == MODE_BLINK_MAX || led.current_mode == MODE_BLINK_LEVEL)
            r = led.current_mode;
         else if (led.current_mode == MODE_OFF || led.current_mode == MODE_ON)
            r = MODE_BLINK_MAX;
         else
            r = MODE_BLINK_LEVEL;
      end
      return r;
   endfunction

   task automatic issue_command(input logic [4:0] m, input logic [15:0] phases, input int step);
      logic [4:0] spec;
      spec = resolve_mode(m);
      if (spec != led.requested_mode) begin
         run_mode(spec, phases, step);
         led.ticks_since_drive = '0;
      end
   endtask

   task automatic predict_pin(input item_type rq, output result_type want);
      int          lo, hi, target, delta;
      logic        ok, stepped;
      logic [15:0] eff;
      ok      = 1'b0;
      stepped = 1'b0;
      case (rq.kind)
         KIND_TICK: begin
            if (led.ticks_since_drive != 16'hFFFF)
               led.ticks_since_drive = led.ticks_since_drive + 16'd1;
            if (led.step_interval > 0 && led.ticks_since_drive >= led.step_interval) begin
               run_mode(led.current_mode, '0, 0);
               led.ticks_since_drive = '0;
               stepped = 1'b1;
            end
         end
         KIND_CMD: begin
            if (rq.mode <= MODE_LAST) issue_command(rq.mode, rq.phase_count, rq.step_amount);
         end
         KIND_SET: begin
            lo     = floor_level();
            hi     = ceil_level();
            target = int'(rq.new_level) << LEVEL_FP_BITS;
            ok     = 1'b1;
            if (target == 0) issue_command(MODE_OFF, '0, 0);
            else if (target == FULL_LEVEL) issue_command(MODE_ON, '0, 0);
            else if (target == lo) issue_command(MODE_LOW, '0, 0);
            else if (target == hi) issue_command(MODE_HIGH, '0, 0);
            else if (cfg.use_pwm) begin
               ok = (target >= lo && target <= hi);
               if (target < lo) target = lo;
               else if (target > hi) target = hi;
               led.level_fixed       = 16'(target);
               led.requested_mode    = MODE_HOLD;
               led.current_mode      = MODE_HOLD;
               led.ticks_since_drive = '0;
            end else begin
               ok = 1'b0;
            end
         end
         default: begin
            delta = (rq.step_amount == 0) ? default_step()
                                          : int'(rq.step_amount) << LEVEL_FP_BITS;
            if (rq.nudge_up) raise_level(delta);
            else lower_level(delta);
         end
      endcase
      eff = cfg.invert_output ? FULL_LEVEL - led.level_fixed : led.level_fixed;
      want.pin_on      = (eff[15:8] != 0);
      want.pin_duty    = (eff[15:8] == 0) ? 8'd0 : (cfg.use_pwm ? eff[15:8] : 8'hFF);
      want.level_now   = led.level_fixed[15:8];
      want.active_mode = led.current_mode;
      want.accepted    = ok;
      want.updated     = stepped;
      want.rising      = (led.step_interval != 0) && led.direction_up;
      want.falling     = (led.step_interval != 0) && !led.direction_up;
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_total++;
         if (mismatch_total <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      item_type   rq;
      result_type want, got;
      if (reset) begin
         cfg.level_min        = 8'd0;
         cfg.level_max        = 8'd255;
         cfg.level_step       = 16'd256;
         cfg.use_pwm          = 1'b1;
         cfg.invert_output    = 1'b0;
         cfg.blink_period     = 16'd1000;
         cfg.refresh_interval = 16'd10;
         led                  = '0;
         led.requested_mode   = MODE_OFF;
         led.current_mode     = MODE_OFF;
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_LEVEL_MIN:     cfg.level_min        = csr_wdata[7:0];
               CSR_LEVEL_MAX:     cfg.level_max        = csr_wdata[7:0];
               CSR_LEVEL_STEP:    cfg.level_step       = csr_wdata;
               CSR_USE_PWM:       cfg.use_pwm          = csr_wdata[0];
               CSR_INVERT_OUTPUT: cfg.invert_output    = csr_wdata[0];
               CSR_BLINK_PERIOD:  cfg.blink_period     = csr_wdata;
               CSR_REFRESH:       cfg.refresh_interval = csr_wdata;
               default: ;
            endcase
         end
         // results first, so a report never meets the request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.pin_on      = rsp_tdata[0];
            got.pin_duty    = rsp_tdata[8:1];
            got.level_now   = rsp_tdata[16:9];
            got.active_mode = rsp_tdata[21:17];
            got.accepted    = rsp_tdata[22];
            got.updated     = rsp_tdata[23];
            got.rising      = rsp_tdata[24];
            got.falling     = rsp_tdata[25];
            if (expected_reports.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= REPORT_LIMIT)
                  $display("%0t: report with no request outstanding, expected none, actual %h",
                           $time, rsp_tdata);
            end else begin
               want = expected_reports.pop_front();
               compare_field("pin_on", want.pin_on, got.pin_on);
               compare_field("pin_duty", want.pin_duty, got.pin_duty);
               compare_field("level_now", want.level_now, got.level_now);
               compare_field("active_mode", want.active_mode, got.active_mode);
               compare_field("accepted", want.accepted, got.accepted);
               compare_field("updated", want.updated, got.updated);
               compare_field("rising", want.rising, got.rising);
               compare_field("falling", want.falling, got.falling);
               report_total++;
               if (want.updated) update_total++;
            end
         end
         if (req_tvalid && req_tready) begin
            rq.kind        = req_tuser;
            rq.mode        = req_tdata[4:0];
            rq.phase_count = req_tdata[20:5];
            rq.step_amount = req_tdata[28:21];
            rq.new_level   = req_tdata[36:29];
            rq.nudge_up    = req_tdata[37];
            predict_pin(rq, want);
            expected_reports.push_back(want);
         end
      end
      waiting       <= expected_reports.size();
      mismatches    <= mismatch_total;
      reports_seen  <= report_total;
      timed_updates <= update_total;
   end

endmodule

/* tb/sv/led_effect_mode_engine_tb.sv */
// Testbench top for the LED effect mode engine: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on lem_pkg, led_pin_checker and the engine.
`timescale 1ns / 1ps

module led_effect_mode_engine_tb;
   import lem_pkg::*;

   localparam int         LONG_HOLD_CYCLES = 300;
   localparam int         TIMEOUT_NS       = 6_000_000;
   localparam logic [4:0] UNUSED_MODE      = 5'd31;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = CSR_LEVEL_MIN;
   logic [15:0] csr_wdata  = '0;

   int   mismatches, waiting, reports_seen, timed_updates;
   int   requests_sent  = 0;
   int   settings_used  = 0;
   bit   idling         = 1'b1;
   bit   hold_request   = 1'b0;
   logic [7:0] min_now  = 8'd0;
   logic [7:0] max_now  = 8'd255;

   led_effect_mode_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   led_pin_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .waiting       (waiting),
      .reports_seen  (reports_seen),
      .timed_updates (timed_updates)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d reports outstanding", waiting);
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (idling && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (idling ? $urandom_range(1, 16) : 1) @(posedge clock);
      end
   end

   // holds valid high across back-to-back requests; only a gap lowers it
   task automatic offer(input logic [1:0] kind, input logic [4:0] mode,
                        input logic [15:0] phases, input logic [7:0] amount,
                        input logic [7:0] level, input logic up);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, up, level, amount, phases, mode};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_setting(input logic [7:0] lmin, input logic [7:0] lmax,
                               input logic [15:0] step, input logic pwm, input logic inv,
                               input logic [15:0] blink, input logic [15:0] refresh);
      drain();
      write_reg(CSR_LEVEL_MIN, {8'd0, lmin});
      write_reg(CSR_LEVEL_MAX, {8'd0, lmax});
      write_reg(CSR_LEVEL_STEP, step);
      write_reg(CSR_USE_PWM, {15'd0, pwm});
      write_reg(CSR_INVERT_OUTPUT, {15'd0, inv});
      write_reg(CSR_BLINK_PERIOD, blink);
      write_reg(CSR_REFRESH, refresh);
      csr_we  <= 1'b0;
      min_now  = lmin;
      max_now  = lmax;
      settings_used++;
   endtask

   function automatic logic [4:0] pick_mode();
      if ($urandom_range(0, 19) == 0) return 5'($urandom_range(MODE_LAST + 1, UNUSED_MODE));
      return 5'($urandom_range(MODE_OFF, MODE_LAST));
   endfunction

   function automatic logic [15:0] pick_phases();
      case ($urandom_range(0, 3))
         0:       return 16'd0;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [7:0] pick_amount();
      return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
   endfunction

   // bound values, the extremes and neighbours of the bounds are the interesting targets
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'hFF;
         2:       return min_now;
         3:       return max_now;
         4:       return min_now - 8'd1;
         5:       return max_now + 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   // a mode command followed by a run of ticks, with the odd level set or nudge between
   task automatic random_phase(input int count);
      int target, k, burst;
      target = requests_sent + count;
      while (requests_sent < target) begin
         offer(KIND_CMD, pick_mode(), pick_phases(), pick_amount(), 8'($urandom), 1'($urandom));
         burst = $urandom_range(0, 30);
         for (k = 0; k < burst; k++) begin
            case ($urandom_range(0, 9))
               0: offer(KIND_SET, 5'($urandom), 16'($urandom), 8'($urandom), pick_level(),
                        1'($urandom));
               1: offer(KIND_NUDGE, 5'($urandom), 16'($urandom), pick_amount(), 8'($urandom),
                        1'($urandom));
               default: offer(KIND_TICK, 5'($urandom), 16'($urandom), 8'($urandom),
                              8'($urandom), 1'($urandom));
            endcase
         end
      end
   endtask

   initial begin
      int m, k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // every mode at the reset settings, with field extremes
      for (m = MODE_OFF; m <= MODE_LAST; m++)
         offer(KIND_CMD, 5'(m), m[0] ? 16'hFFFF : 16'h0000, m[1] ? 8'hFF : 8'h00, 8'hFF, 1'b1);
      offer(KIND_CMD, UNUSED_MODE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
      offer(KIND_CMD, MODE_HOLD, 16'h0000, 8'h00, 8'h00, 1'b0);
      offer(KIND_SET, MODE_OFF, 16'h0000, 8'h00, 8'h00, 1'b0);
      offer(KIND_SET, MODE_OFF, 16'h0000, 8'h00, 8'hFF, 1'b0);
      offer(KIND_SET, MODE_OFF, 16'h0000, 8'h00, 8'd100, 1'b0);
      offer(KIND_NUDGE, MODE_OFF, 16'h0000, 8'h00, 8'h00, 1'b1);
      offer(KIND_NUDGE, MODE_OFF, 16'h0000, 8'hFF, 8'h00, 1'b0);
      offer(KIND_TICK, UNUSED_MODE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);

      load_setting(8'd0, 8'd255, 16'd256, 1'b1, 1'b0, 16'd6, 16'd3);
      random_phase(200);

      // output held off while ticks keep coming, so the engine has to stall its input
      hold_request = 1'b1;
      offer(KIND_CMD, MODE_OSCILLATE, 16'd0, 8'd0, 8'd0, 1'b0);
      for (k = 0; k < 120; k++)
         offer(KIND_TICK, MODE_OFF, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      drain();
      random_phase(100);

      load_setting(8'd40, 8'd200, 16'h0180, 1'b1, 1'b1, 16'd4, 16'd2);
      random_phase(220);
      load_setting(8'd200, 8'd50, 16'h0C00, 1'b1, 1'b0, 16'd2, 16'd1);
      random_phase(220);
      load_setting(8'd0, 8'd0, 16'd0, 1'b1, 1'b1, 16'd0, 16'd0);
      random_phase(200);
      load_setting(8'd128, 8'd128, 16'hFF00, 1'b0, 1'b0, 16'd1, 16'hFFFF);
      random_phase(150);
      load_setting(8'd254, 8'd255, 16'd1, 1'b1, 1'b1, 16'hFFFF, 16'd1);
      random_phase(150);
      load_setting(8'd10, 8'd245, 16'h0333, 1'b0, 1'b1, 16'd3, 16'd5);
      random_phase(200);

      idling = 1'b0;
      load_setting(8'd0, 8'd255, 16'h0800, 1'b1, 1'b0, 16'd8, 16'd2);
      random_phase(200);

      drain();
      repeat (8) @(posedge clock);
      $display("%0d requests over %0d register settings, %0d reports checked, %0d timed steps",
               requests_sent, settings_used, reports_seen, timed_updates);
      $display("covered all modes, bound swaps, zero step and period, digital remap, inversion");
      if (mismatches == 0 && waiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
